// ----- sv/srat_pkg.sv -----
// Shared types, widths and codes for the syscall rule action table.
package srat_pkg;

  localparam int MAX_RULES = 64;
  localparam int KEY_W     = 10;
  localparam int ACT_W     = 2;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int ENTRY_W   = KEY_W + ACT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_CHECK  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  localparam logic [ACT_W-1:0] ACT_ALLOW = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALERT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_COMMIT = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic commit;
  } cmd_t;

endpackage

// ----- sv/srat_req_if.sv -----
// Request channel interface: valid, ready and the request payload.
interface srat_req_if;
  logic                       valid;
  logic                       ready;
  logic [srat_pkg::REQ_W-1:0] req_type;
  logic [srat_pkg::KEY_W-1:0] call_num;
  logic [srat_pkg::ACT_W-1:0] rule_action;

  modport source (output valid, output req_type, output call_num, output rule_action,
                  input ready);
  modport sink (input valid, input req_type, input call_num, input rule_action,
                output ready);
endinterface

// ----- sv/srat_rsp_if.sv -----
// Result channel interface: valid, ready and the result payload.
interface srat_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srat_pkg::STAT_W-1:0] status;
  logic [srat_pkg::ACT_W-1:0]  verdict;
  logic                        matched;
  logic [srat_pkg::CNT_W-1:0]  rules_in_use;

  modport source (output valid, output status, output verdict, output matched,
                  output rules_in_use, input ready);
  modport sink (input valid, input status, input verdict, input matched,
                input rules_in_use, output ready);
endinterface

// ----- sv/syscall_rule_action_table.sv -----
// Top level of the syscall rule action table: controller plus datapath.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      req_type, call_num, rule_action
//   out_ch    source     valid / ready      status, verdict, matched, rules_in_use
//   cfg       write      cfg_we             cfg_wdata (permit_unmatched)
//
// Each item passes through three steps: the accept step compares the key against
// every stored key in parallel, the read step reads the entry memory at the match
// slot and at the last slot, and the commit step makes the one memory write and
// loads the result register. Reset (rst_n low, synchronous) empties the table
// by clearing the rule count; no clearing pass runs. A stalled result holds
// the item in its commit cycle until the result register drains, and input
// is taken again as soon as the commit is done.
module syscall_rule_action_table (
  input  logic        clk,
  input  logic        rst_n,
  srat_req_if.sink    in_ch,
  srat_rsp_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  srat_pkg::cmd_t cmd;

  // The controller owns the handshakes and the order of the three steps.
  srat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath holds the table, the count, the register and the result.
  srat_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_ch.req_type),
    .in_call_num      (in_ch.call_num),
    .in_rule_action   (in_ch.rule_action),
    .out_status       (out_ch.status),
    .out_verdict      (out_ch.verdict),
    .out_matched      (out_ch.matched),
    .out_rules_in_use (out_ch.rules_in_use)
  );

endmodule

// ----- sv/srat_ctrl.sv -----
// Controller state machine: sequences lookup, memory read and commit of one item.
module srat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output srat_pkg::cmd_t  cmd
);

  srat_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srat_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      srat_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = srat_pkg::S_READ;
        end
      end
      srat_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = srat_pkg::S_COMMIT;
      end
      srat_pkg::S_COMMIT: begin
        // The result register must be free or draining this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = srat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srat_pkg::S_IDLE;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/srat_dp.sv -----
// Datapath: key compare cells, entry memory, rule count and result registers.
module srat_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srat_pkg::cmd_t              cmd,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic [srat_pkg::REQ_W-1:0]  in_req_type,
  input  logic [srat_pkg::KEY_W-1:0]  in_call_num,
  input  logic [srat_pkg::ACT_W-1:0]  in_rule_action,
  output logic [srat_pkg::STAT_W-1:0] out_status,
  output logic [srat_pkg::ACT_W-1:0]  out_verdict,
  output logic                        out_matched,
  output logic [srat_pkg::CNT_W-1:0]  out_rules_in_use
);

  localparam int N  = srat_pkg::MAX_RULES;
  localparam int IW = srat_pkg::IDX_W;
  localparam int CW = srat_pkg::CNT_W;
  localparam int KW = srat_pkg::KEY_W;
  localparam int AW = srat_pkg::ACT_W;
  localparam int EW = srat_pkg::ENTRY_W;

  // Key cells, each compared against the request key at its own place.
  logic [KW-1:0] key_cells_r [N];
  // Entry memory holding {key, action}, read at the match slot and the last slot.
  logic [EW-1:0] rule_mem [N];

  logic [CW-1:0]       count_r, count_nxt;
  logic                permit_unmatched_r;
  srat_pkg::req_type_t req_r;
  logic [KW-1:0]       key_r;
  logic [AW-1:0]       act_r;
  logic                hit_r;
  logic [IW-1:0]       slot_r;
  logic [EW-1:0]       rd_slot_r, rd_last_r;

  logic [N-1:0]        match;
  logic [IW-1:0]       slot_enc;
  logic [CW-1:0]       cnt_m1;
  logic [IW-1:0]       last_idx;
  logic                full;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic                cam_we;
  logic [IW-1:0]       cam_waddr;
  logic [KW-1:0]       cam_wkey;
  srat_pkg::status_t   status_nxt;
  logic [AW-1:0]       verdict_nxt;
  logic                matched_nxt;

  assign cnt_m1   = count_r - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign full     = (count_r == CW'(N));

  // Parallel compare over the entries below the count.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (key_cells_r[i] == in_call_num) && (CW'(i) < count_r);
    end
  end

  // Keys are unique, so at most one match bit is set and an OR encoder suffices.
  always_comb begin
    logic [IW-1:0] idx_v;
    slot_enc = '0;
    for (int i = 0; i < N; i++) begin
      idx_v = IW'(i);
      for (int b = 0; b < IW; b++) begin
        if (match[i] && idx_v[b]) begin
          slot_enc[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      permit_unmatched_r <= 1'b0;
    end else if (cfg_we) begin
      permit_unmatched_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= srat_pkg::req_type_t'(in_req_type);
      key_r  <= in_call_num;
      act_r  <= in_rule_action;
      hit_r  <= |match;
      slot_r <= slot_enc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_slot_r <= rule_mem[slot_r];
      rd_last_r <= rule_mem[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cam_we) begin
      key_cells_r[cam_waddr] <= cam_wkey;
    end
  end

  // Commit decisions for the captured request.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = slot_r;
    mem_wdata   = {key_r, act_r};
    cam_we      = 1'b0;
    cam_waddr   = slot_r;
    cam_wkey    = key_r;
    count_nxt   = count_r;
    status_nxt  = srat_pkg::ST_OK;
    verdict_nxt = srat_pkg::ACT_ALLOW;
    matched_nxt = 1'b0;
    case (req_r)
      srat_pkg::REQ_ADD: begin
        if (hit_r) begin
          mem_we = 1'b1;
        end else if (full) begin
          status_nxt = srat_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = count_r[IW-1:0];
          cam_we    = 1'b1;
          cam_waddr = count_r[IW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      srat_pkg::REQ_REMOVE: begin
        if (hit_r) begin
          if (slot_r != last_idx) begin
            mem_we    = 1'b1;
            mem_wdata = rd_last_r;
            cam_we    = 1'b1;
            cam_wkey  = rd_last_r[EW-1:AW];
          end
          count_nxt = cnt_m1;
        end else begin
          status_nxt = srat_pkg::ST_NOT_FOUND;
        end
      end
      srat_pkg::REQ_UPDATE: begin
        if (hit_r) begin
          mem_we = 1'b1;
        end else begin
          status_nxt = srat_pkg::ST_NOT_FOUND;
        end
      end
      srat_pkg::REQ_CHECK: begin
        matched_nxt = hit_r;
        if (hit_r) begin
          verdict_nxt = rd_slot_r[AW-1:0];
        end else if (permit_unmatched_r) begin
          verdict_nxt = srat_pkg::ACT_ALLOW;
        end else begin
          verdict_nxt = srat_pkg::ACT_ALERT;
        end
      end
      default: begin
        status_nxt = srat_pkg::ST_OK;
      end
    endcase
    if (!cmd.commit) begin
      mem_we    = 1'b0;
      cam_we    = 1'b0;
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status       <= status_nxt;
      out_verdict      <= verdict_nxt;
      out_matched      <= matched_nxt;
      out_rules_in_use <= count_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_syscall_rule_action_table.sv -----
// Self-checking testbench for the syscall rule action table: directed and random requests.
module tb_syscall_rule_action_table;
  import srat_pkg::*;

  // The cycle watchdog fires when neither channel has made a handshake within
  // this limit. It lies far above the longest sender gap and the longest
  // receiver stall that pick_gap can give, so it leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to let pass after the last result, so that a stray extra result
  // would still show up.
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 220;

  // One expected result, laid out like the result channel payload.
  typedef struct packed {
    status_t          status;
    logic [ACT_W-1:0] verdict;
    logic             matched;
    logic [CNT_W-1:0] rules_in_use;
  } rule_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  srat_req_if in_ch ();
  srat_rsp_if out_ch ();

  syscall_rule_action_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the rule table. Entries at and above rule_total are never
  // read, so their contents do not matter.
  logic [KEY_W-1:0] rule_key_mem [MAX_RULES];
  logic [ACT_W-1:0] rule_act_mem [MAX_RULES];
  int               rule_total;
  logic             unknown_allowed;

  // Results that the table still owes, oldest first.
  rule_result_t pending_results[$];

  // When set, neither side inserts gaps or stalls.
  bit no_gaps;

  int n_errors;
  int n_sent;
  int n_checked;
  int n_hits;
  int n_full;
  int n_missing;
  int n_cfg_writes;
  int idle_cycles;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Random gap length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Slot that holds the key, or -1 when no rule names it.
  function automatic int find_rule(logic [KEY_W-1:0] key);
    for (int i = 0; i < rule_total; i++) begin
      if (rule_key_mem[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result that the
  // block must produce for it.
  function automatic rule_result_t apply_request(req_type_t rt, logic [KEY_W-1:0] key,
                                                 logic [ACT_W-1:0] act);
    rule_result_t res;
    int           slot;
    int           last;
    res.status  = ST_OK;
    res.verdict = '0;
    res.matched = 1'b0;
    slot = find_rule(key);
    case (rt)
      REQ_ADD: begin
        if (slot >= 0) begin
          rule_act_mem[slot] = act;
        end else if (rule_total >= MAX_RULES) begin
          res.status = ST_FULL;
        end else begin
          rule_key_mem[rule_total] = key;
          rule_act_mem[rule_total] = act;
          rule_total++;
        end
      end
      REQ_REMOVE: begin
        if (slot >= 0) begin
          // The last entry fills the hole, unless it is the one removed.
          last = rule_total - 1;
          if (slot < last) begin
            rule_key_mem[slot] = rule_key_mem[last];
            rule_act_mem[slot] = rule_act_mem[last];
          end
          rule_total = last;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      REQ_UPDATE: begin
        if (slot >= 0) begin
          rule_act_mem[slot] = act;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (slot >= 0) begin
          res.matched = 1'b1;
          res.verdict = rule_act_mem[slot];
        end else begin
          res.verdict = unknown_allowed ? ACT_ALLOW : ACT_ALERT;
        end
      end
    endcase
    res.rules_in_use = rule_total[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Sends one request item. The task is entered at or after a rising edge and
  // returns at the rising edge where the item was accepted, with valid still
  // high; the next send or idle_bus decides at the falling edge what follows.
  task automatic send_request(req_type_t rt, logic [KEY_W-1:0] key, logic [ACT_W-1:0] act);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.req_type    = rt;
    in_ch.call_num    = key;
    in_ch.rule_action = act;
    forever begin
      @(posedge clk);
      if (in_ch.ready) begin
        break;
      end
    end
    pending_results.push_back(apply_request(rt, key, act));
    n_sent++;
  endtask

  // Lowers valid at the next falling edge, so that the last item is not taken twice.
  task automatic idle_bus();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Holds the sender back until every expected result has arrived.
  task automatic wait_drained();
    idle_bus();
    while (pending_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Writes the unmatched-check setting while the table is idle and mirrors it
  // in the shadow copy.
  task automatic write_permit_unmatched(logic value);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    unknown_allowed = value;
    n_cfg_writes++;
  endtask

  // Hand-picked requests: empty table, keys at both ends of the range,
  // overwrite, update, the move on remove, and the removal of the last entry.
  task automatic test_directed();
    send_request(REQ_CHECK,  10'd0,    2'd3);
    send_request(REQ_CHECK,  10'd1023, 2'd0);
    send_request(REQ_REMOVE, 10'd5,    2'd1);
    send_request(REQ_UPDATE, 10'd5,    2'd3);
    send_request(REQ_ADD,    10'd0,    2'd0);
    send_request(REQ_ADD,    10'd1023, 2'd3);
    send_request(REQ_ADD,    10'h155,  2'd1);
    send_request(REQ_ADD,    10'h2AA,  2'd2);
    send_request(REQ_CHECK,  10'd0,    2'd3);
    send_request(REQ_CHECK,  10'd1023, 2'd3);
    send_request(REQ_CHECK,  10'h155,  2'd0);
    send_request(REQ_CHECK,  10'h2AA,  2'd1);
    // Adding an existing key only overwrites its action.
    send_request(REQ_ADD,    10'h155,  2'd3);
    send_request(REQ_CHECK,  10'h155,  2'd0);
    send_request(REQ_UPDATE, 10'd1023, 2'd1);
    send_request(REQ_CHECK,  10'd1023, 2'd2);
    // Removing slot 0 moves the newest rule into it.
    send_request(REQ_REMOVE, 10'd0,    2'd2);
    send_request(REQ_CHECK,  10'h2AA,  2'd0);
    send_request(REQ_CHECK,  10'd0,    2'd1);
    send_request(REQ_REMOVE, 10'h2AA,  2'd3);
    // The key 1023 now sits in the last slot, so no move happens.
    send_request(REQ_REMOVE, 10'd1023, 2'd0);
    send_request(REQ_REMOVE, 10'h155,  2'd1);
    send_request(REQ_CHECK,  10'h155,  2'd2);
    send_request(REQ_UPDATE, 10'd0,    2'd2);
    wait_drained();
  endtask

  // Unmatched checks under both settings of the unmatched-check register.
  task automatic test_permit_unmatched();
    write_permit_unmatched(1'b1);
    send_request(REQ_CHECK, 10'd77,  2'd0);
    send_request(REQ_ADD,   10'd77,  2'd2);
    send_request(REQ_CHECK, 10'd77,  2'd3);
    send_request(REQ_CHECK, 10'd512, 2'd1);
    write_permit_unmatched(1'b0);
    send_request(REQ_CHECK, 10'd512, 2'd1);
    send_request(REQ_CHECK, 10'd77,  2'd0);
    send_request(REQ_REMOVE, 10'd77, 2'd0);
    send_request(REQ_CHECK, 10'd77,  2'd0);
    wait_drained();
  endtask

  // Fills the table to the last slot, probes it while full, then empties it
  // in random order.
  task automatic test_table_full();
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    int               idx;
    base = KEY_W'($urandom_range(0, 1023));
    for (int i = 0; i < MAX_RULES; i++) begin
      // A stride of 13 keeps all keys distinct across the 10-bit range.
      key = base + KEY_W'(i * 13);
      send_request(REQ_ADD, key, 2'($urandom_range(0, 3)));
    end
    // A new key is refused, an existing one is still overwritten.
    send_request(REQ_ADD, base + KEY_W'(MAX_RULES * 13), 2'd1);
    send_request(REQ_ADD, base, 2'd3);
    send_request(REQ_ADD, base + KEY_W'((MAX_RULES - 1) * 13), 2'd2);
    for (int i = 0; i < 16; i++) begin
      idx = $urandom_range(0, rule_total - 1);
      send_request(REQ_CHECK, rule_key_mem[idx], 2'($urandom_range(0, 3)));
    end
    send_request(REQ_UPDATE, rule_key_mem[MAX_RULES / 2], 2'd0);
    send_request(REQ_CHECK,  rule_key_mem[MAX_RULES / 2], 2'd3);
    while (rule_total > 0) begin
      idx = $urandom_range(0, rule_total - 1);
      send_request(REQ_REMOVE, rule_key_mem[idx], 2'($urandom_range(0, 3)));
    end
    send_request(REQ_CHECK, base, 2'd0);
    wait_drained();
  endtask

  // One random request. Keys come mostly from rules held and from a small
  // pool, so that adds, removes and checks hit each other often.
  task automatic send_random(int add_pct, int rem_pct, int upd_pct,
                             logic [KEY_W-1:0] pool_base, int pool_span);
    int               r;
    logic [KEY_W-1:0] key;
    req_type_t        rt;
    r = $urandom_range(0, 99);
    if (r < 35 && rule_total > 0) begin
      key = rule_key_mem[$urandom_range(0, rule_total - 1)];
    end else if (r < 85) begin
      key = pool_base + KEY_W'($urandom_range(0, pool_span - 1));
    end else begin
      key = KEY_W'($urandom_range(0, 1023));
    end
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      rt = REQ_ADD;
    end else if (r < add_pct + rem_pct) begin
      rt = REQ_REMOVE;
    end else if (r < add_pct + rem_pct + upd_pct) begin
      rt = REQ_UPDATE;
    end else begin
      rt = REQ_CHECK;
    end
    send_request(rt, key, 2'($urandom_range(0, 3)));
  endtask

  // Random phases with different request mixes: steady traffic, a growth
  // phase that runs into the full table, a shrink phase, a phase without
  // gaps and wide-range keys. The unmatched-check setting is rewritten at
  // each phase boundary.
  task automatic test_random();
    int add_pct [RANDOM_PHASES] = '{40, 65, 15, 30, 30, 35};
    int rem_pct [RANDOM_PHASES] = '{20, 10, 55, 25, 25, 20};
    int upd_pct [RANDOM_PHASES] = '{15, 10, 10, 15, 15, 15};
    int span    [RANDOM_PHASES] = '{48, 120, 96, 64, 1024, 80};
    logic [KEY_W-1:0] pool_base;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_permit_unmatched(p < 4 ? p[0] == 1'b0 : 1'($urandom_range(0, 1)));
      no_gaps   = (p == 3);
      pool_base = KEY_W'($urandom_range(0, 1023));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Midway, wait until every outstanding result has arrived before going on.
        if (i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        send_random(add_pct[p], rem_pct[p], upd_pct[p], pool_base, span[p]);
      end
      no_gaps = 1'b0;
    end
    wait_drained();
  endtask

  // Receiver: ready changes only at the falling edge, with random stalls.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready = 1'b0;
          stall--;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  // Each accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_checker
    rule_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result with no request outstanding", $time);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.matched) begin
          n_hits++;
        end
        if (want.status == ST_FULL) begin
          n_full++;
        end
        if (want.status == ST_NOT_FOUND) begin
          n_missing++;
        end
        if (out_ch.status !== want.status) begin
          report_mismatch("status", out_ch.status, want.status);
        end
        if (out_ch.verdict !== want.verdict) begin
          report_mismatch("verdict", out_ch.verdict, want.verdict);
        end
        if (out_ch.matched !== want.matched) begin
          report_mismatch("matched", out_ch.matched, want.matched);
        end
        if (out_ch.rules_in_use !== want.rules_in_use) begin
          report_mismatch("rules_in_use", out_ch.rules_in_use, want.rules_in_use);
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_ADD;
    in_ch.call_num    = '0;
    in_ch.rule_action = '0;
    rule_total        = 0;
    unknown_allowed   = 1'b0;
    no_gaps           = 1'b0;
    n_errors          = 0;
    n_sent            = 0;
    n_checked         = 0;
    n_hits            = 0;
    n_full            = 0;
    n_missing         = 0;
    n_cfg_writes      = 0;
    idle_cycles       = 0;
    for (int i = 0; i < MAX_RULES; i++) begin
      rule_key_mem[i] = '0;
      rule_act_mem[i] = '0;
    end

    // Synchronous reset, held low from time zero and released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_permit_unmatched();
    test_table_full();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results: %0d check hits,",
             n_sent, n_checked, n_hits);
    $display("%0d table-full, %0d not-found, %0d setting writes and %0d mismatches.",
             n_full, n_missing, n_cfg_writes, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
